/* sv/rmcc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the RLE mask color compositor.
// No dependencies; the other files that use it refer to this package by scoped names.
package rmcc_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int PIX_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(PIX_DEPTH);

    localparam int CFG_W       = 7;
    localparam int OP_W        = 2;
    localparam int CAT_W       = 8;
    localparam int RUN_W       = 13;
    localparam int POS_W       = 13;
    localparam int RD_W        = 6;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int STAT_W      = 2;
    localparam int HASH_W      = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [HASH_W-1:0] HASH_MUL = 32'h045d9f3b;
    localparam int HASH_SHIFT  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam int DIV_STEPS   = POS_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_START = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_DROP = 2'd1,
        ST_OOB  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                 op;
        logic [COLOR_W-1:0]  color;
        logic [RUN_W-1:0]    run;
        logic [ADDR_W-1:0]   raddr;
        logic                rd_oob;
    } t_cmd;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input int max_v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > CFG_W'(max_v)) begin
            res = CFG_W'(max_v);
        end
        return res;
    endfunction

endpackage

/* sv/rmcc_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rmcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rmcc_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: run position by image height.
// Depends on rmcc_pkg.
module rmcc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rmcc_pkg::POS_W-1:0]     i_dividend,
    input  logic [rmcc_pkg::CFG_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic [rmcc_pkg::POS_W-1:0]     o_quot,
    output logic [rmcc_pkg::CFG_W-1:0]     o_rem
);

    logic                              r_busy;
    logic                              r_done;
    logic [rmcc_pkg::DIV_CNT_W-1:0]    r_step;
    logic [rmcc_pkg::POS_W-1:0]        r_dvd;
    logic [rmcc_pkg::POS_W-1:0]        r_quo;
    logic [rmcc_pkg::CFG_W-1:0]        r_rem;
    logic [rmcc_pkg::CFG_W-1:0]        r_dsr;
    logic [rmcc_pkg::CFG_W:0]          w_trial;
    logic                              w_ge;

    assign w_trial = {r_rem, r_dvd[rmcc_pkg::POS_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= rmcc_pkg::DIV_CNT_W'(rmcc_pkg::DIV_STEPS - 1);
            r_dvd  <= i_dividend;
            r_quo  <= '0;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            r_dvd  <= {r_dvd[rmcc_pkg::POS_W-2:0], 1'b0};
            r_quo  <= {r_quo[rmcc_pkg::POS_W-2:0], w_ge};
            r_rem  <= w_ge ? rmcc_pkg::CFG_W'(w_trial - {1'b0, r_dsr})
                           : rmcc_pkg::CFG_W'(w_trial);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* sv/rmcc_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on rmcc_pkg.
module rmcc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rmcc_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output rmcc_pkg::t_cmd      o_cmd
);

    rmcc_pkg::t_cmd                r_mem [rmcc_pkg::Q_DEPTH];
    logic [rmcc_pkg::Q_PTR_W-1:0]  r_wp;
    logic [rmcc_pkg::Q_PTR_W-1:0]  r_rp;
    logic [rmcc_pkg::Q_CNT_W-1:0]  r_cnt;
    logic                          w_push;
    logic                          w_pop;

    assign o_full  = (r_cnt == rmcc_pkg::Q_CNT_W'(rmcc_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == rmcc_pkg::Q_PTR_W'(rmcc_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == rmcc_pkg::Q_PTR_W'(rmcc_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rmcc_pkg::Q_CNT_W'(rmcc_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && i_push |-> 1'b0)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

/* sv/rmcc_front.sv */
`timescale 1ns / 1ps
// Front end: takes requests, decodes them, hashes the category into a color
// and bounds-checks reads, then pushes a command. Depends on rmcc_pkg.
module rmcc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_init_done,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rmcc_pkg::OP_W-1:0]      i_opcode,
    input  logic [rmcc_pkg::CAT_W-1:0]     i_category_index,
    input  logic [rmcc_pkg::RUN_W-1:0]     i_run_length,
    input  logic [rmcc_pkg::RD_W-1:0]      i_read_column,
    input  logic [rmcc_pkg::RD_W-1:0]      i_read_row,
    input  logic [rmcc_pkg::CFG_W-1:0]     i_eff_width,
    input  logic [rmcc_pkg::CFG_W-1:0]     i_eff_height,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output rmcc_pkg::t_cmd                 o_q_cmd
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                          r_state;
    rmcc_pkg::t_cmd                   r_cmd;
    logic [rmcc_pkg::HASH_W-1:0]      r_h1;
    logic [rmcc_pkg::HASH_W-1:0]      w_mix;
    logic [rmcc_pkg::HASH_W-1:0]      w_prod;
    logic                             w_accept;

    assign o_ready  = (r_state == F_IDLE) && i_init_done;
    assign w_accept = i_valid && o_ready;
    assign w_mix    = r_h1 ^ (r_h1 >> rmcc_pkg::HASH_SHIFT);
    assign w_prod   = rmcc_pkg::HASH_W'(w_mix * rmcc_pkg::HASH_MUL);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_state <= (rmcc_pkg::t_op'(i_opcode) == rmcc_pkg::OP_START)
                                   ? F_HASH : F_PUSH;
                    end
                end
                F_HASH: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // first round: the shifted term of an 8-bit value is zero
            r_h1         <= rmcc_pkg::HASH_W'(rmcc_pkg::HASH_W'(i_category_index)
                                              * rmcc_pkg::HASH_MUL);
            r_cmd.op     <= rmcc_pkg::t_op'(i_opcode);
            r_cmd.color  <= '0;
            r_cmd.run    <= i_run_length;
            r_cmd.raddr  <= rmcc_pkg::ADDR_W'(
                                rmcc_pkg::ADDR_W'(i_read_row)
                                * rmcc_pkg::ADDR_W'(rmcc_pkg::MAX_WIDTH)
                                + rmcc_pkg::ADDR_W'(i_read_column));
            r_cmd.rd_oob <= ({1'b0, i_read_column} >= i_eff_width)
                         || ({1'b0, i_read_row} >= i_eff_height);
        end else if (r_state == F_HASH) begin
            r_cmd.color  <= rmcc_pkg::COLOR_W'(w_prod ^ (w_prod >> rmcc_pkg::HASH_SHIFT));
        end
    end

endmodule

/* sv/rmcc_back.sv */
`timescale 1ns / 1ps
// Back end: executes commands against the canvas RAM, walks draw runs one
// pixel per cycle and holds the result register. Depends on rmcc_pkg,
// rmcc_ram and rmcc_div.
module rmcc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rmcc_pkg::CFG_W-1:0]     i_eff_width,
    input  logic [rmcc_pkg::CFG_W-1:0]     i_eff_height,
    input  logic                           i_q_empty,
    input  rmcc_pkg::t_cmd                 i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_init_done,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rmcc_pkg::CHAN_W-1:0]    o_channel_low,
    output logic [rmcc_pkg::CHAN_W-1:0]    o_channel_mid,
    output logic [rmcc_pkg::CHAN_W-1:0]    o_channel_high,
    output logic [rmcc_pkg::STAT_W-1:0]    o_status
);

    typedef enum logic [6:0] {
        B_CLR  = 7'b0000001,
        B_IDLE = 7'b0000010,
        B_EXEC = 7'b0000100,
        B_DIV  = 7'b0001000,
        B_DRAW = 7'b0010000,
        B_RD   = 7'b0100000,
        B_RESP = 7'b1000000
    } t_bstate;

    t_bstate                          r_state;
    logic                             r_init_done;
    logic [rmcc_pkg::ADDR_W-1:0]      r_clr_addr;
    rmcc_pkg::t_cmd                   r_cmd;
    logic [rmcc_pkg::COLOR_W-1:0]     r_color_cur;
    logic [rmcc_pkg::POS_W-1:0]       r_pos;
    logic                             r_phase;
    logic [rmcc_pkg::COL_W-1:0]       r_col;
    logic [rmcc_pkg::ROW_W-1:0]       r_row;
    logic [rmcc_pkg::POS_W-1:0]       r_cnt;
    logic [rmcc_pkg::COLOR_W-1:0]     r_res_color;
    rmcc_pkg::t_status                r_res_status;
    logic                             r_wr_pend;
    logic [rmcc_pkg::ADDR_W-1:0]      r_wr_addr;
    logic                             r_out_valid;
    logic [rmcc_pkg::COLOR_W-1:0]     r_out_color;
    rmcc_pkg::t_status                r_out_status;

    logic [rmcc_pkg::POS_W-1:0]       w_total;
    logic [rmcc_pkg::POS_W-1:0]       w_pc;
    logic [rmcc_pkg::POS_W-1:0]       w_room;
    logic [rmcc_pkg::POS_W-1:0]       w_skip_pos;
    logic [rmcc_pkg::POS_W-1:0]       w_n;
    logic                             w_over;
    logic [rmcc_pkg::ADDR_W-1:0]      w_draw_addr;
    logic                             w_row_wrap;
    logic                             w_clr;
    logic                             w_we;
    logic [rmcc_pkg::ADDR_W-1:0]      w_waddr;
    logic [rmcc_pkg::COLOR_W-1:0]     w_wdata;
    logic [rmcc_pkg::ADDR_W-1:0]      w_raddr;
    logic [rmcc_pkg::COLOR_W-1:0]     w_rdata;
    logic                             w_div_start;
    logic                             w_div_done;
    logic [rmcc_pkg::POS_W-1:0]       w_div_quot;
    logic [rmcc_pkg::CFG_W-1:0]       w_div_rem;
    logic                             w_out_free;

    assign w_total    = rmcc_pkg::POS_W'(i_eff_width * i_eff_height);
    assign w_pc       = (r_pos > w_total) ? w_total : r_pos;
    assign w_room     = w_total - w_pc;
    assign w_over     = (r_cmd.run > w_room);
    assign w_skip_pos = w_over ? w_total : w_pc + r_cmd.run;
    assign w_n        = w_over ? w_room : r_cmd.run;

    assign w_draw_addr = rmcc_pkg::ADDR_W'(
                             rmcc_pkg::ADDR_W'(r_row) * rmcc_pkg::ADDR_W'(rmcc_pkg::MAX_WIDTH)
                             + rmcc_pkg::ADDR_W'(r_col));
    assign w_row_wrap  = ({1'b0, r_row} + 1'b1 == i_eff_height);

    assign w_clr   = (r_state == B_CLR);
    assign w_we    = w_clr || r_wr_pend;
    assign w_waddr = w_clr ? r_clr_addr : r_wr_addr;
    assign w_wdata = w_clr ? '0 : (w_rdata | r_color_cur);
    assign w_raddr = (r_state == B_DRAW) ? w_draw_addr : r_cmd.raddr;

    assign w_div_start = (r_state == B_EXEC) && (r_cmd.op == rmcc_pkg::OP_RUN)
                      && r_phase && (w_n != '0);
    assign w_out_free  = !r_out_valid || i_ready;

    assign o_q_pop     = (r_state == B_IDLE) && !i_q_empty;
    assign o_init_done = r_init_done;

    rmcc_ram #(
        .WIDTH (rmcc_pkg::COLOR_W),
        .DEPTH (rmcc_pkg::PIX_DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rmcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_pc),
        .i_divisor  (i_eff_height),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_init_done <= 1'b0;
            r_clr_addr  <= '0;
            r_color_cur <= '0;
            r_pos       <= '0;
            r_phase     <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= (r_state == B_DRAW);
            if (r_state == B_RESP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == rmcc_pkg::ADDR_W'(rmcc_pkg::PIX_DEPTH - 1)) begin
                        r_init_done <= 1'b1;
                        r_state     <= r_init_done ? B_RESP : B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= B_EXEC;
                    end
                end
                B_EXEC: begin
                    case (r_cmd.op)
                        rmcc_pkg::OP_CLEAR: begin
                            r_clr_addr <= '0;
                            r_state    <= B_CLR;
                        end
                        rmcc_pkg::OP_START: begin
                            r_color_cur <= r_cmd.color;
                            r_pos       <= '0;
                            r_phase     <= 1'b0;
                            r_state     <= B_RESP;
                        end
                        rmcc_pkg::OP_RUN: begin
                            r_phase <= !r_phase;
                            if (!r_phase) begin
                                r_pos   <= w_skip_pos;
                                r_state <= B_RESP;
                            end else begin
                                r_pos   <= w_pc + w_n;
                                r_state <= (w_n == '0) ? B_RESP : B_DIV;
                            end
                        end
                        rmcc_pkg::OP_READ: begin
                            r_state <= r_cmd.rd_oob ? B_RESP : B_RD;
                        end
                        default: r_state <= B_RESP;
                    endcase
                end
                B_DIV: begin
                    if (w_div_done) begin
                        r_state <= B_DRAW;
                    end
                end
                B_DRAW: begin
                    if (r_cnt == rmcc_pkg::POS_W'(1)) begin
                        r_state <= B_RESP;
                    end
                end
                B_RD: begin
                    r_state <= B_RESP;
                end
                B_RESP: begin
                    if (w_out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == B_DRAW) begin
            r_wr_addr <= w_draw_addr;
        end
        case (r_state)
            B_CLR: begin
                r_res_color  <= '0;
                r_res_status <= rmcc_pkg::ST_OK;
            end
            B_EXEC: begin
                r_res_color  <= '0;
                r_cnt        <= w_n;
                if (r_cmd.op == rmcc_pkg::OP_RUN && r_phase && w_over) begin
                    r_res_status <= rmcc_pkg::ST_DROP;
                end else if (r_cmd.op == rmcc_pkg::OP_READ && r_cmd.rd_oob) begin
                    r_res_status <= rmcc_pkg::ST_OOB;
                end else begin
                    r_res_status <= rmcc_pkg::ST_OK;
                end
            end
            B_DIV: begin
                r_col <= rmcc_pkg::COL_W'(w_div_quot);
                r_row <= rmcc_pkg::ROW_W'(w_div_rem);
            end
            B_DRAW: begin
                r_cnt <= r_cnt - 1'b1;
                if (w_row_wrap) begin
                    r_row <= '0;
                    r_col <= r_col + 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
            B_RD: begin
                r_res_color <= w_rdata;
            end
            B_RESP: begin
                if (w_out_free) begin
                    r_out_color  <= r_res_color;
                    r_out_status <= r_res_status;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_channel_low  = r_out_color[7:0];
    assign o_channel_mid  = r_out_color[15:8];
    assign o_channel_high = r_out_color[23:16];
    assign o_status       = r_out_status;

    a_draw_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DRAW) |-> (r_cnt != '0))
        else $error("draw with no pixels left");

    a_draw_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DRAW) |-> ({1'b0, r_row} < i_eff_height))
        else $error("draw row beyond image height");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= rmcc_pkg::POS_W'(rmcc_pkg::PIX_DEPTH))
        else $error("run position beyond canvas");

endmodule

/* sv/rle_mask_color_compositor_core.sv */
`timescale 1ns / 1ps
// Top level of the RLE mask color compositor: config registers, front end,
// command queue and back end. Depends on rmcc_pkg, rmcc_front, rmcc_queue, rmcc_back.
//
//  Channel   Handshake            Payload
//  request   i_valid / o_ready    i_opcode i_category_index i_run_length i_read_column i_read_row
//  result    o_valid / i_ready    o_channel_low o_channel_mid o_channel_high o_status
//  config    i_cfg_we             i_cfg_idx i_cfg_data
//
// A draw run goes through the 13-step position divider and then makes one
// canvas RAM write per pixel; a clear writes one canvas word per cycle.
// After reset a clearing pass over the whole canvas runs with o_ready low.
// The queue lets the front take requests while the back works or the result
// register waits on i_ready.
module rle_mask_color_compositor_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [rmcc_pkg::OP_W-1:0]          i_opcode,
    input  logic [rmcc_pkg::CAT_W-1:0]         i_category_index,
    input  logic [rmcc_pkg::RUN_W-1:0]         i_run_length,
    input  logic [rmcc_pkg::RD_W-1:0]          i_read_column,
    input  logic [rmcc_pkg::RD_W-1:0]          i_read_row,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [rmcc_pkg::CHAN_W-1:0]        o_channel_low,
    output logic [rmcc_pkg::CHAN_W-1:0]        o_channel_mid,
    output logic [rmcc_pkg::CHAN_W-1:0]        o_channel_high,
    output logic [rmcc_pkg::STAT_W-1:0]        o_status,
    input  logic                               i_cfg_we,
    input  logic [rmcc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rmcc_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [rmcc_pkg::CFG_W-1:0]   r_cfg_width;
    logic [rmcc_pkg::CFG_W-1:0]   r_cfg_height;
    logic [rmcc_pkg::CFG_W-1:0]   w_eff_width;
    logic [rmcc_pkg::CFG_W-1:0]   w_eff_height;
    logic                         w_init_done;
    logic                         w_q_push;
    logic                         w_q_pop;
    logic                         w_q_full;
    logic                         w_q_empty;
    rmcc_pkg::t_cmd               w_front_cmd;
    rmcc_pkg::t_cmd               w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= rmcc_pkg::CFG_W'(rmcc_pkg::MAX_WIDTH);
            r_cfg_height <= rmcc_pkg::CFG_W'(rmcc_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rmcc_pkg::CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data;
                rmcc_pkg::CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data;
                default: r_cfg_width <= r_cfg_width;
            endcase
        end
    end

    assign w_eff_width  = rmcc_pkg::eff_dim(r_cfg_width, rmcc_pkg::MAX_WIDTH);
    assign w_eff_height = rmcc_pkg::eff_dim(r_cfg_height, rmcc_pkg::MAX_HEIGHT);

    rmcc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_init_done      (w_init_done),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_category_index (i_category_index),
        .i_run_length     (i_run_length),
        .i_read_column    (i_read_column),
        .i_read_row       (i_read_row),
        .i_eff_width      (w_eff_width),
        .i_eff_height     (w_eff_height),
        .i_q_full         (w_q_full),
        .o_q_push         (w_q_push),
        .o_q_cmd          (w_front_cmd)
    );

    rmcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_cmd   (w_q_cmd)
    );

    rmcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_eff_width    (w_eff_width),
        .i_eff_height   (w_eff_height),
        .i_q_empty      (w_q_empty),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_q_pop),
        .o_init_done    (w_init_done),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_channel_low  (o_channel_low),
        .o_channel_mid  (o_channel_mid),
        .o_channel_high (o_channel_high),
        .o_status       (o_status)
    );

endmodule

/* sim/tb_rle_mask_color_compositor_core.sv */
`timescale 1ns / 1ps
// Self-checking bench for rle_mask_color_compositor_core: a directed stimulus table, then
// random annotation streams, checked against an in-bench canvas predictor or fixed results.
// Depends on rmcc_pkg and the core RTL.
module tb_rle_mask_color_compositor_core;

    localparam int     HALF_PERIOD  = 6;
    localparam longint LIMIT_NS     = 400_000_000;
    localparam int     HOLD_CYCLES  = 800;
    localparam int     RANDOM_ITEMS = 1830;
    localparam int     N_PHASES     = 9;

    typedef struct {
        rmcc_pkg::t_op               op;
        logic [rmcc_pkg::CAT_W-1:0]  cat;
        logic [rmcc_pkg::RUN_W-1:0]  run;
        logic [rmcc_pkg::RD_W-1:0]   col;
        logic [rmcc_pkg::RD_W-1:0]   row;
    } t_req;

    typedef struct {
        logic [rmcc_pkg::CHAN_W-1:0] lo;
        logic [rmcc_pkg::CHAN_W-1:0] mid;
        logic [rmcc_pkg::CHAN_W-1:0] hi;
        rmcc_pkg::t_status           st;
    } t_pix;

    typedef struct {
        bit                             is_cfg;
        t_req                           req;
        bit                             fixed;
        rmcc_pkg::t_status              fixed_st;
        logic [rmcc_pkg::CFG_IDX_W-1:0] idx;
        logic [rmcc_pkg::CFG_W-1:0]     data;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [rmcc_pkg::OP_W-1:0]      i_opcode;
    logic [rmcc_pkg::CAT_W-1:0]     i_category_index;
    logic [rmcc_pkg::RUN_W-1:0]     i_run_length;
    logic [rmcc_pkg::RD_W-1:0]      i_read_column;
    logic [rmcc_pkg::RD_W-1:0]      i_read_row;
    logic                           o_valid;
    logic                           i_ready;
    logic [rmcc_pkg::CHAN_W-1:0]    o_channel_low;
    logic [rmcc_pkg::CHAN_W-1:0]    o_channel_mid;
    logic [rmcc_pkg::CHAN_W-1:0]    o_channel_high;
    logic [rmcc_pkg::STAT_W-1:0]    o_status;
    logic                           i_cfg_we;
    logic [rmcc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [rmcc_pkg::CFG_W-1:0]     i_cfg_data;

    rle_mask_color_compositor_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_opcode         (i_opcode),
        .i_category_index (i_category_index),
        .i_run_length     (i_run_length),
        .i_read_column    (i_read_column),
        .i_read_row       (i_read_row),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_channel_low    (o_channel_low),
        .o_channel_mid    (o_channel_mid),
        .o_channel_high   (o_channel_high),
        .o_status         (o_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // predictor state
    logic [rmcc_pkg::COLOR_W-1:0] canvas_img [rmcc_pkg::MAX_WIDTH][rmcc_pkg::MAX_HEIGHT];
    logic [rmcc_pkg::COLOR_W-1:0] pen_color;
    int                           pen_pos;
    bit                           pen_draw;
    logic [rmcc_pkg::CFG_W-1:0]   width_reg;
    logic [rmcc_pkg::CFG_W-1:0]   height_reg;

    t_pix pending_pixels [$];
    t_row stim_table [$];
    int   mismatches;
    int   burst_left;
    bit   hold_req;

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int clamp_dim(input logic [rmcc_pkg::CFG_W-1:0] v, input int max_v);
        if (v == '0) return 1;
        if (int'(v) > max_v) return max_v;
        return int'(v);
    endfunction

    function automatic logic [rmcc_pkg::COLOR_W-1:0] category_color(
        input logic [rmcc_pkg::CAT_W-1:0] c);
        logic [rmcc_pkg::HASH_W-1:0] v;
        v = rmcc_pkg::HASH_W'(c);
        v = ((v >> rmcc_pkg::HASH_SHIFT) ^ v) * rmcc_pkg::HASH_MUL;
        v = ((v >> rmcc_pkg::HASH_SHIFT) ^ v) * rmcc_pkg::HASH_MUL;
        v = (v >> rmcc_pkg::HASH_SHIFT) ^ v;
        return v[rmcc_pkg::COLOR_W-1:0];
    endfunction

    function automatic t_pix paint_pixels(input t_req r);
        t_pix                         res;
        int                           w;
        int                           h;
        int                           total;
        int                           p;
        logic [rmcc_pkg::COLOR_W-1:0] c;
        w      = clamp_dim(width_reg, rmcc_pkg::MAX_WIDTH);
        h      = clamp_dim(height_reg, rmcc_pkg::MAX_HEIGHT);
        total  = w * h;
        c      = '0;
        res.st = rmcc_pkg::ST_OK;
        case (r.op)
            rmcc_pkg::OP_CLEAR: begin
                for (int x = 0; x < rmcc_pkg::MAX_WIDTH; x++)
                    for (int y = 0; y < rmcc_pkg::MAX_HEIGHT; y++)
                        canvas_img[x][y] = '0;
            end
            rmcc_pkg::OP_START: begin
                pen_color = category_color(r.cat);
                pen_pos   = 0;
                pen_draw  = 1'b0;
            end
            rmcc_pkg::OP_RUN: begin
                p = (pen_pos > total) ? total : pen_pos;
                if (pen_draw) begin
                    for (int i = 0; i < int'(r.run); i++) begin
                        if (p >= total) begin
                            res.st = rmcc_pkg::ST_DROP;
                            break;
                        end
                        canvas_img[p / h][p % h] |= pen_color;
                        p++;
                    end
                end else begin
                    p = (int'(r.run) > total - p) ? total : p + int'(r.run);
                end
                pen_pos  = p;
                pen_draw = !pen_draw;
            end
            default: begin
                if (int'(r.col) >= w || int'(r.row) >= h)
                    res.st = rmcc_pkg::ST_OOB;
                else
                    c = canvas_img[r.col][r.row];
            end
        endcase
        res.lo  = c[7:0];
        res.mid = c[15:8];
        res.hi  = c[23:16];
        return res;
    endfunction

    function automatic t_req mk_req(input rmcc_pkg::t_op op, input int cat, input int run,
                                    input int col, input int row);
        t_req r;
        r.op  = op;
        r.cat = rmcc_pkg::CAT_W'(cat);
        r.run = rmcc_pkg::RUN_W'(run);
        r.col = rmcc_pkg::RD_W'(col);
        r.row = rmcc_pkg::RD_W'(row);
        return r;
    endfunction

    task automatic row_item(input t_req r, input bit fixed, input rmcc_pkg::t_status st);
        t_row t;
        t.is_cfg   = 1'b0;
        t.req      = r;
        t.fixed    = fixed;
        t.fixed_st = st;
        t.idx      = '0;
        t.data     = '0;
        stim_table.push_back(t);
    endtask

    task automatic row_cfg(input logic [rmcc_pkg::CFG_IDX_W-1:0] idx, input int data);
        t_row t;
        t.is_cfg   = 1'b1;
        t.req      = mk_req(rmcc_pkg::OP_CLEAR, 0, 0, 0, 0);
        t.fixed    = 1'b0;
        t.fixed_st = rmcc_pkg::ST_OK;
        t.idx      = idx;
        t.data     = rmcc_pkg::CFG_W'(data);
        stim_table.push_back(t);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(input t_req r, input bit fixed, input rmcc_pkg::t_status fst);
        t_pix px;
        int   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_opcode         = r.op;
        i_category_index = r.cat;
        i_run_length     = r.run;
        i_read_column    = r.col;
        i_read_row       = r.row;
        i_valid          = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        px = paint_pixels(r);
        if (fixed) begin
            px.lo  = '0;
            px.mid = '0;
            px.hi  = '0;
            px.st  = fst;
        end
        pending_pixels.push_back(px);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rmcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rmcc_pkg::CFG_W-1:0] data);
        i_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        if (idx == rmcc_pkg::CFG_IDX_WIDTH)
            width_reg = data;
        else
            height_reg = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic int pick_run();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return $urandom_range(0, 12);
        if (k < 80) return $urandom_range(0, clamp_dim(height_reg, rmcc_pkg::MAX_HEIGHT));
        if (k < 95) return $urandom_range(0, 300);
        return $urandom_range(0, 8191);
    endfunction

    function automatic t_req pick_read();
        int cmax;
        int rmax;
        cmax = ($urandom_range(0, 2) == 0) ? 63
             : clamp_dim(width_reg, rmcc_pkg::MAX_WIDTH) - 1;
        rmax = ($urandom_range(0, 2) == 0) ? 63
             : clamp_dim(height_reg, rmcc_pkg::MAX_HEIGHT) - 1;
        return mk_req(rmcc_pkg::OP_READ, $urandom_range(0, 255), $urandom_range(0, 8191),
                      $urandom_range(0, cmax), $urandom_range(0, rmax));
    endfunction

    task automatic random_phase(input int n_items, input bit squeeze);
        int k;
        int n_runs;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if (squeeze && sent >= 40 && sent < 50)
                hold_req = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 70) begin
                send_req(mk_req(rmcc_pkg::OP_START, $urandom_range(0, 255), 0, 0, 0),
                         1'b0, rmcc_pkg::ST_OK);
                sent++;
                n_runs = $urandom_range(1, 14);
                for (int j = 0; j < n_runs; j++) begin
                    send_req(mk_req(rmcc_pkg::OP_RUN, $urandom_range(0, 255), pick_run(),
                                    $urandom_range(0, 63), $urandom_range(0, 63)),
                             1'b0, rmcc_pkg::ST_OK);
                    sent++;
                    if ($urandom_range(0, 4) == 0) begin
                        send_req(pick_read(), 1'b0, rmcc_pkg::ST_OK);
                        sent++;
                    end
                end
            end else if (k < 90) begin
                repeat ($urandom_range(1, 4)) begin
                    send_req(pick_read(), 1'b0, rmcc_pkg::ST_OK);
                    sent++;
                end
            end else if (k < 94) begin
                send_req(mk_req(rmcc_pkg::OP_CLEAR, $urandom_range(0, 255),
                                $urandom_range(0, 8191), $urandom_range(0, 63),
                                $urandom_range(0, 63)), 1'b0, rmcc_pkg::ST_OK);
                sent++;
            end else begin
                send_req(mk_req(rmcc_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 255),
                                $urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 63)), 1'b0, rmcc_pkg::ST_OK);
                sent++;
            end
        end
    endtask

    // stimulus
    initial begin
        int w_set;
        int h_set;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_opcode         = rmcc_pkg::OP_CLEAR;
        i_category_index = '0;
        i_run_length     = '0;
        i_read_column    = '0;
        i_read_row       = '0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = rmcc_pkg::CFG_IDX_WIDTH;
        i_cfg_data       = '0;
        hold_req         = 1'b0;
        burst_left       = 0;
        mismatches       = 0;
        for (int x = 0; x < rmcc_pkg::MAX_WIDTH; x++)
            for (int y = 0; y < rmcc_pkg::MAX_HEIGHT; y++)
                canvas_img[x][y] = '0;
        pen_color  = '0;
        pen_pos    = 0;
        pen_draw   = 1'b0;
        width_reg  = rmcc_pkg::CFG_W'(rmcc_pkg::MAX_WIDTH);
        height_reg = rmcc_pkg::CFG_W'(rmcc_pkg::MAX_HEIGHT);

        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 63, 63), 1'b1, rmcc_pkg::ST_OK);
        // skip before any start
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 5, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        // draw with zero color
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 3, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_START, 0, 0, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 0, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 64, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 0, 10), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_START, 254, 0, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_START, 255, 0, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        // skip saturates
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 8191, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        // draw past the end
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 1, 0, 0), 1'b1, rmcc_pkg::ST_DROP);
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_CLEAR, 0, 0, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        row_cfg(rmcc_pkg::CFG_IDX_WIDTH, 0);                     // clamps to one column
        row_cfg(rmcc_pkg::CFG_IDX_HEIGHT, 127);                  // clamps to max height
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 1, 0), 1'b1, rmcc_pkg::ST_OOB);
        row_item(mk_req(rmcc_pkg::OP_START, 90, 0, 0, 0), 1'b1, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 0, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 4096, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 0, 63), 1'b0, rmcc_pkg::ST_OK);
        row_cfg(rmcc_pkg::CFG_IDX_WIDTH, 3);
        row_cfg(rmcc_pkg::CFG_IDX_HEIGHT, 1);
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 0, 1), 1'b1, rmcc_pkg::ST_OOB);
        // position clamped to new size
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 1, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_RUN, 0, 2, 0, 0), 1'b0, rmcc_pkg::ST_OK);
        row_item(mk_req(rmcc_pkg::OP_READ, 0, 0, 2, 0), 1'b0, rmcc_pkg::ST_OK);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg)
                write_reg(stim_table[i].idx, stim_table[i].data);
            else
                send_req(stim_table[i].req, stim_table[i].fixed, stim_table[i].fixed_st);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       begin w_set = 64;  h_set = 64;  end
                1:       begin w_set = 1;   h_set = 1;   end
                2:       begin w_set = 0;   h_set = 127; end
                3:       begin w_set = 127; h_set = 0;   end
                4:       begin w_set = 65;  h_set = 3;   end
                5:       begin w_set = 64;  h_set = 1;   end
                default: begin
                    w_set = $urandom_range(1, 64);
                    h_set = $urandom_range(1, 64);
                end
            endcase
            write_reg(rmcc_pkg::CFG_IDX_WIDTH, rmcc_pkg::CFG_W'(w_set));
            write_reg(rmcc_pkg::CFG_IDX_HEIGHT, rmcc_pkg::CFG_W'(h_set));
            random_phase(RANDOM_ITEMS / N_PHASES, ph == 2 || ph == 6);
        end

        i_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // result-side backpressure
    initial begin
        int             mode;
        int             mode_left;
        int             ptr;
        logic [15:0]    stall_pat;
        i_ready   = 1'b0;
        mode      = 0;
        mode_left = 0;
        ptr       = 0;
        stall_pat = '1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 400);
                    stall_pat = 16'($urandom);
                end
                mode_left--;
                case (mode)
                    0: i_ready = 1'b1;
                    1: i_ready = 1'($urandom_range(0, 1));
                    2: begin
                        i_ready = stall_pat[ptr];
                        ptr     = (ptr + 1) % 16;
                    end
                    default: i_ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        t_pix want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result: expected none, got low %0h mid %0h high %0h st %0d",
                         $time, o_channel_low, o_channel_mid, o_channel_high, o_status);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_channel_low !== want.lo) begin
                    $display("%0t: channel_low expected %0h got %0h", $time, want.lo,
                             o_channel_low);
                    mismatches++;
                end
                if (o_channel_mid !== want.mid) begin
                    $display("%0t: channel_mid expected %0h got %0h", $time, want.mid,
                             o_channel_mid);
                    mismatches++;
                end
                if (o_channel_high !== want.hi) begin
                    $display("%0t: channel_high expected %0h got %0h", $time, want.hi,
                             o_channel_high);
                    mismatches++;
                end
                if (o_status !== want.st) begin
                    $display("%0t: status expected %0d got %0d", $time, want.st, o_status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
